>>> hdl/obd_seg_pkg.sv
// shared types and constants for the multi-pid response segmenter
// no dependencies
package obd_seg_pkg;

  localparam logic [7:0] RESPONSE_MODE_RESET = 8'h41;
  localparam int unsigned LEN_W = 3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] frame_len;
    logic       frame_first;
  } seg_item_t;

  typedef struct packed {
    logic [7:0]       seg_id;
    logic [7:0]       seg_data;
    logic [LEN_W-1:0] seg_offset;
    logic [LEN_W-1:0] seg_length;
    logic             seg_last;
  } seg_result_t;

endpackage

>>> hdl/obd_seg_pid_lut.sv
// fixed pid to data length table, zero for an unknown pid
// depends on obd_seg_pkg
module obd_seg_pid_lut (
  input  logic [7:0]                   pid,
  output logic [obd_seg_pkg::LEN_W-1:0] len
);

  always_comb begin
    unique case (pid)
      8'h04, 8'h06, 8'h07, 8'h0B, 8'h0D, 8'h0E, 8'h11, 8'h2E,
      8'h30, 8'h33, 8'h47, 8'h49, 8'h4A, 8'h51, 8'h55, 8'h56: len = 3'd1;
      8'h0C, 8'h15, 8'h1F, 8'h21, 8'h31, 8'h3C, 8'h42, 8'h43,
      8'h44: len = 3'd2;
      8'h67: len = 3'd3;
      8'h24: len = 3'd4;
      8'h66: len = 3'd5;
      8'h68: len = 3'd7;
      default: len = 3'd0;
    endcase
  end

endmodule

>>> hdl/obd_seg_parser.sv
// input register, frame parse state and mode register
// depends on obd_seg_pkg and obd_seg_pid_lut
module obd_seg_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [7:0]               cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  obd_seg_pkg::seg_item_t   in_item,
  input  logic                     res_ready,
  output logic                     res_valid,
  output obd_seg_pkg::seg_result_t res
);

  logic                   item_valid;
  obd_seg_pkg::seg_item_t item;
  logic                   fire;

  logic [7:0] response_mode;
  logic [7:0] byte_pos, byte_pos_next;
  logic [7:0] held_frame_len, held_frame_len_next;
  logic [7:0] current_id, current_id_next;
  logic [2:0] bytes_left, bytes_left_next;
  logic [2:0] seg_pos, seg_pos_next;
  logic [2:0] seg_len_held, seg_len_held_next;
  logic       halted, halted_next;

  logic [2:0] lut_len;
  logic [9:0] seg_end;

  obd_seg_pid_lut u_lut (
    .pid (item.rx_byte),
    .len (lut_len)
  );

  assign fire     = item_valid && res_ready;
  assign in_stall = item_valid && !res_ready;
  assign seg_end  = {2'b00, byte_pos} + 10'd1 + {7'd0, lut_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (res_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response_mode <= obd_seg_pkg::RESPONSE_MODE_RESET;
    end else if (cfg_wr_en) begin
      response_mode <= cfg_wr_data;
    end
  end

  always_comb begin
    byte_pos_next       = byte_pos;
    held_frame_len_next = held_frame_len;
    current_id_next     = current_id;
    bytes_left_next     = bytes_left;
    seg_pos_next        = seg_pos;
    seg_len_held_next   = seg_len_held;
    halted_next         = halted;
    res_valid           = 1'b0;
    res.seg_id          = current_id;
    res.seg_data        = item.rx_byte;
    res.seg_offset      = seg_pos;
    res.seg_length      = seg_len_held;
    res.seg_last        = (bytes_left == 3'd1);
    if (fire) begin
      priority if (item.frame_first) begin
        held_frame_len_next = item.frame_len;
        byte_pos_next       = 8'd1;
        bytes_left_next     = 3'd0;
        seg_pos_next        = 3'd0;
        halted_next         = (item.frame_len == 8'd0) || (item.rx_byte != response_mode);
      end else if (halted) begin
        halted_next = 1'b1;
      end else if (byte_pos >= held_frame_len) begin
        halted_next = 1'b1;
      end else if (bytes_left == 3'd0) begin
        if (lut_len == 3'd0 || seg_end > {2'b00, held_frame_len}) begin
          halted_next = 1'b1;
        end else begin
          current_id_next   = item.rx_byte;
          seg_len_held_next = lut_len;
          bytes_left_next   = lut_len;
          seg_pos_next      = 3'd0;
          byte_pos_next     = byte_pos + 8'd1;
        end
      end else begin
        res_valid       = 1'b1;
        seg_pos_next    = seg_pos + 3'd1;
        bytes_left_next = bytes_left - 3'd1;
        byte_pos_next   = byte_pos + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos       <= '0;
      held_frame_len <= '0;
      current_id     <= '0;
      bytes_left     <= '0;
      seg_pos        <= '0;
      seg_len_held   <= '0;
      halted         <= 1'b1;
    end else begin
      byte_pos       <= byte_pos_next;
      held_frame_len <= held_frame_len_next;
      current_id     <= current_id_next;
      bytes_left     <= bytes_left_next;
      seg_pos        <= seg_pos_next;
      seg_len_held   <= seg_len_held_next;
      halted         <= halted_next;
    end
  end

endmodule

>>> hdl/obd_seg_out_reg.sv
// result register toward the receiver, loads whenever empty or being taken
// depends on obd_seg_pkg
module obd_seg_out_reg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     res_valid,
  input  obd_seg_pkg::seg_result_t res,
  output logic                     res_ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output obd_seg_pkg::seg_result_t out_res
);

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

>>> hdl/obd_multi_pid_segmenter_unit.sv
// top level of the multi-pid response segmenter
// depends on obd_seg_pkg, obd_seg_parser, obd_seg_out_reg
//
// input channel: one frame byte per transaction (rx_byte, frame_len,
// frame_first), handshake in_valid / in_stall
// output channel: one transaction per data byte of a known pid segment
// (seg_id, seg_data, seg_offset, seg_length, seg_last), out_valid / out_stall
// header and pid bytes, unknown pids and truncated segments give nothing
// cfg_wr_en / cfg_wr_data write the expected response mode byte
// a byte taken is held in the input register and its result is then loaded into
// the result register, which drives the outputs
// throughput: one byte per cycle while the receiver does not stall, set by the
// single stage of pid table lookup and frame length compare between input and result registers
// a stalled receiver holds the result register; one more byte is taken
// into the input register, then in_stall rises until the result is taken
// reset: mode byte back to 0x41, both registers empty, parse waits for
// a frame_first byte
module obd_multi_pid_segmenter_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic [7:0] frame_len,
  input  logic       frame_first,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] seg_id,
  output logic [7:0] seg_data,
  output logic [2:0] seg_offset,
  output logic [2:0] seg_length,
  output logic       seg_last
);

  obd_seg_pkg::seg_item_t   in_item;
  obd_seg_pkg::seg_result_t res;
  obd_seg_pkg::seg_result_t out_res;
  logic                     res_valid;
  logic                     res_ready;

  assign in_item.rx_byte     = rx_byte;
  assign in_item.frame_len   = frame_len;
  assign in_item.frame_first = frame_first;

  obd_seg_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res         (res)
  );

  obd_seg_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign seg_id     = out_res.seg_id;
  assign seg_data   = out_res.seg_data;
  assign seg_offset = out_res.seg_offset;
  assign seg_length = out_res.seg_length;
  assign seg_last   = out_res.seg_last;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result register not empty after reset");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seg_length != 3'd0)
    else $error("result with zero segment length");

  a_last_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (seg_last == (({1'b0, seg_offset} + 4'd1) == {1'b0, seg_length})))
    else $error("last flag does not match offset and length");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seg_offset < seg_length)
    else $error("segment offset beyond segment length");

endmodule

>>> dv/obd_multi_pid_segmenter_unit_tb.sv
// self-checking testbench for obd_multi_pid_segmenter_unit: frame bytes go in, pid data bytes
// are predicted by a local parser and compared field by field in arrival order
// depends on obd_seg_pkg and the segmenter rtl
`timescale 1ns / 1ps

module obd_multi_pid_segmenter_unit_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 370;
  localparam int LONG_HOLD = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic [7:0] frame_len = 8'h00;
  logic       frame_first = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] seg_id;
  logic [7:0] seg_data;
  logic [2:0] seg_offset;
  logic [2:0] seg_length;
  logic       seg_last;

  obd_multi_pid_segmenter_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .frame_len(frame_len),
    .frame_first(frame_first),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .seg_id(seg_id),
    .seg_data(seg_data),
    .seg_offset(seg_offset),
    .seg_length(seg_length),
    .seg_last(seg_last)
  );

  always #10 clk = ~clk;

  obd_seg_pkg::seg_item_t   frame_bytes_q[$];
  obd_seg_pkg::seg_result_t want_segs[$];
  obd_seg_pkg::seg_item_t   drv_byte;

  int errs = 0;
  int n_queued = 0;
  int n_taken = 0;
  int n_checked = 0;
  int n_frames = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int gap_cnt = 0;
  int stall_cnt = 0;
  int hold_cnt = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  bit sender_hold = 1'b0;

  // parser state mirrored from the block
  logic [7:0] p_mode = obd_seg_pkg::RESPONSE_MODE_RESET;
  logic [7:0] p_pos = 8'd0;
  logic [7:0] p_flen = 8'd0;
  logic [7:0] p_id = 8'd0;
  logic [2:0] p_left = 3'd0;
  logic [2:0] p_spos = 3'd0;
  logic [2:0] p_slen = 3'd0;
  bit         p_halt = 1'b1;

  // pid table entry k as {id, data length}
  function automatic logic [10:0] pid_entry(int k);
    case (k)
      0:  return {8'h04, 3'd1};
      1:  return {8'h06, 3'd1};
      2:  return {8'h07, 3'd1};
      3:  return {8'h0B, 3'd1};
      4:  return {8'h0C, 3'd2};
      5:  return {8'h0D, 3'd1};
      6:  return {8'h0E, 3'd1};
      7:  return {8'h11, 3'd1};
      8:  return {8'h15, 3'd2};
      9:  return {8'h1F, 3'd2};
      10: return {8'h21, 3'd2};
      11: return {8'h24, 3'd4};
      12: return {8'h2E, 3'd1};
      13: return {8'h30, 3'd1};
      14: return {8'h31, 3'd2};
      15: return {8'h33, 3'd1};
      16: return {8'h3C, 3'd2};
      17: return {8'h42, 3'd2};
      18: return {8'h43, 3'd2};
      19: return {8'h44, 3'd2};
      20: return {8'h47, 3'd1};
      21: return {8'h49, 3'd1};
      22: return {8'h4A, 3'd1};
      23: return {8'h51, 3'd1};
      24: return {8'h55, 3'd1};
      25: return {8'h56, 3'd1};
      26: return {8'h66, 3'd5};
      27: return {8'h67, 3'd3};
      28: return {8'h68, 3'd7};
      default: return 11'd0;
    endcase
  endfunction

  function automatic int pid_data_len(logic [7:0] id);
    logic [10:0] e;
    for (int k = 0; k < 29; k++) begin
      e = pid_entry(k);
      if (e[10:3] == id) return int'(e[2:0]);
    end
    return 0;
  endfunction

  // advance the parser by one accepted byte, queue the data byte it yields
  function automatic void segment_byte(obd_seg_pkg::seg_item_t it);
    int dlen;
    obd_seg_pkg::seg_result_t r;
    if (it.frame_first) begin
      p_flen = it.frame_len;
      p_pos = 8'd1;
      p_left = 3'd0;
      p_spos = 3'd0;
      p_halt = (it.frame_len == 8'd0) || (it.rx_byte != p_mode);
      return;
    end
    if (p_halt) return;
    if (p_pos >= p_flen) begin
      p_halt = 1'b1;
      return;
    end
    if (p_left == 3'd0) begin
      dlen = pid_data_len(it.rx_byte);
      if (dlen == 0 || int'(p_pos) + 1 + dlen > int'(p_flen)) begin
        p_halt = 1'b1;
        return;
      end
      p_id = it.rx_byte;
      p_slen = dlen[2:0];
      p_left = dlen[2:0];
      p_spos = 3'd0;
      p_pos = p_pos + 8'd1;
      return;
    end
    r.seg_id = p_id;
    r.seg_data = it.rx_byte;
    r.seg_offset = p_spos;
    r.seg_length = p_slen;
    r.seg_last = (p_left == 3'd1);
    want_segs.push_back(r);
    p_spos = p_spos + 3'd1;
    p_left = p_left - 3'd1;
    p_pos = p_pos + 8'd1;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errs++;
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte <= 8'h00;
      frame_len <= 8'h00;
      frame_first <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (in_valid && !in_stall) begin
        segment_byte(drv_byte);
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid <= 1'b0;
        end else if (idle_pct > 0 && frame_bytes_q.size() > 0 &&
                     $urandom_range(0, 99) < idle_pct) begin
          gap_cnt = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (frame_bytes_q.size() > 0 && !sender_hold) begin
          drv_byte = frame_bytes_q.pop_front();
          in_valid <= 1'b1;
          rx_byte <= drv_byte.rx_byte;
          frame_len <= drv_byte.frame_len;
          frame_first <= drv_byte.frame_first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall generator
  always @(posedge clk) begin
    obd_seg_pkg::seg_result_t w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_segs.size() == 0) begin
          $error("unexpected transaction: seg_id 0x%0h seg_data 0x%0h", seg_id, seg_data);
          errs++;
        end else begin
          w = want_segs.pop_front();
          check_field("seg_id", w.seg_id, seg_id);
          check_field("seg_data", w.seg_data, seg_data);
          check_field("seg_offset", w.seg_offset, seg_offset);
          check_field("seg_length", w.seg_length, seg_length);
          check_field("seg_last", w.seg_last, seg_last);
          n_checked++;
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_cnt = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, want_segs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] rx, logic [7:0] flen, logic first);
    obd_seg_pkg::seg_item_t it;
    it.rx_byte = rx;
    it.frame_len = flen;
    it.frame_first = first;
    frame_bytes_q.push_back(it);
    n_queued++;
    if (first) n_frames++;
  endtask

  task automatic push_body(logic [7:0] rx);
    push_byte(rx, 8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic add_rand_frame(logic [7:0] mode, bit big);
    logic [7:0] body[$];
    logic [10:0] e;
    logic [7:0] hdr;
    int kind, target, flen, nsend;
    kind = $urandom_range(0, 99);
    target = (big || $urandom_range(0, 199) == 0) ? 254 : $urandom_range(0, 14);
    while (body.size() < target) begin
      if ($urandom_range(0, 24) == 0) begin
        body.push_back(8'($urandom_range(0, 255)));
      end else begin
        e = pid_entry($urandom_range(0, 28));
        body.push_back(e[10:3]);
        repeat (e[2:0]) body.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (body.size() > 254) void'(body.pop_back());
    flen = body.size() + 1;
    hdr = mode;
    nsend = body.size();
    if (kind >= 70 && kind < 78) begin
      flen = $urandom_range(0, 255);
    end else if (kind >= 78 && kind < 85) begin
      hdr = 8'($urandom_range(0, 255));
    end else if (kind >= 85 && kind < 92) begin
      repeat ($urandom_range(1, 4)) body.push_back(8'($urandom_range(0, 255)));
      nsend = body.size();
    end else if (kind >= 92 && kind < 97) begin
      nsend = $urandom_range(0, body.size());
    end else if (kind >= 97) begin
      repeat ($urandom_range(1, 3)) push_body(8'($urandom_range(0, 255)));
    end
    push_byte(hdr, 8'(flen), 1'b1);
    for (int i = 0; i < nsend; i++) push_body(body[i]);
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || want_segs.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_mode(logic [7:0] m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_mode = m;
  endtask

  initial begin
    logic [7:0] mode_list [5];
    int phase_end;
    mode_list[0] = 8'h00;
    mode_list[1] = 8'hFF;
    mode_list[2] = 8'h0C;
    mode_list[3] = 8'($urandom_range(0, 255));
    mode_list[4] = obd_seg_pkg::RESPONSE_MODE_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset mode byte
    idle_pct = 10;
    stall_pct = 10;
    push_body(8'h04);
    push_byte(8'h41, 8'd6, 1'b1);
    push_body(8'h04); push_body(8'h00); push_body(8'h0C); push_body(8'h00); push_body(8'hFF);
    push_byte(8'h42, 8'd3, 1'b1); push_body(8'h04);
    push_byte(8'h41, 8'd0, 1'b1); push_body(8'h04);
    push_byte(8'h41, 8'd3, 1'b1); push_body(8'h05);
    push_byte(8'h41, 8'd4, 1'b1); push_body(8'h24);
    push_byte(8'h41, 8'd1, 1'b1); push_body(8'h04);
    push_byte(8'h41, 8'd9, 1'b1); push_body(8'h68); push_body(8'h01);
    push_byte(8'h41, 8'd255, 1'b1); push_body(8'h68);
    for (int i = 0; i < 7; i++) push_body(8'(i * 37));
    wait_drained();

    // random phases, one mode byte each
    for (int ph = 0; ph < 5; ph++) begin
      write_mode(mode_list[ph]);
      idle_pct = (ph == 4) ? 0 : $urandom_range(5, 40);
      stall_pct = (ph == 4) ? 0 : $urandom_range(5, 40);
      phase_end = n_queued + PHASE_BYTES;
      if (ph == 2) add_rand_frame(mode_list[ph], 1'b1);
      while (n_queued < phase_end) add_rand_frame(mode_list[ph], 1'b0);
      if (ph == 1) hold_reqs++;
      if (ph == 2) begin
        while (frame_bytes_q.size() > PHASE_BYTES / 2) @(negedge clk);
        sender_hold = 1'b1;
        while (want_segs.size() != 0 || in_valid) @(negedge clk);
        repeat (5) @(negedge clk);
        sender_hold = 1'b0;
      end
      wait_drained();
    end

    $display("run covered %0d input bytes in %0d frames and %0d checked data bytes",
             n_taken, n_frames, n_checked);
    $display("mode bytes 0x41, 0x00, 0xFF, 0x0C and 0x%0h, with long output hold", mode_list[3]);
    if (errs == 0 && want_segs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
